// File: design/rtu_pkg.sv
package rtu_pkg;

	// Frame store size and the shortest frame that can be good.
	localparam int FRAME_MAX = 256;
	localparam int FRAME_MIN = 4;
	localparam int FRAME_ADDR_W = $clog2(FRAME_MAX);
	localparam int FRAME_POS_W = $clog2(FRAME_MAX + 1);

	// Silence length after reset, in 50 us ticks.
	localparam logic [15:0] SILENCE_RESET = 16'd35;

	// Modbus CRC-16, reflected form.
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Receiver modes.
	typedef enum logic [1:0] {
		MODE_INIT  = 2'd0,
		MODE_IDLE  = 2'd1,
		MODE_RCV   = 2'd2,
		MODE_ERROR = 2'd3
	} rx_mode_t;

	// Request kinds on the input stream.
	typedef enum logic [1:0] {
		REQ_BYTE    = 2'd0,
		REQ_TICK    = 2'd1,
		REQ_READ    = 2'd2,
		REQ_RESTART = 2'd3
	} req_t;

	// Event kinds on the output stream.
	typedef enum logic [1:0] {
		EV_RX_READY = 2'd0,
		EV_GOOD     = 2'd1,
		EV_BAD      = 2'd2,
		EV_DATA     = 2'd3
	} event_t;

	// One byte step of the CRC, least significant bit first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: design/rtu_ram.sv
// Simple dual-port RAM: one write and one registered read per cycle.
module rtu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: design/rtu_frame_receiver.sv
// Receive framer for serial frames delimited by an inter-frame silence.
// The s_ stream carries one request word per item: a received byte, a
// 50 us timer tick, a read of the frame buffer, or a receiver restart.
// Bytes are stored and fed through a Modbus CRC-16, one byte per word.
// Each byte reloads the silence countdown; ticks count it down. When the
// silence expires the block sends one event word on the m_ stream: ready
// after a restart, or the collected frame as good or bad. A buffer read
// always returns one data word. Frames longer than the buffer are dropped.
// The cfg channel sets the silence length and is always ready.
// A request is taken every cycle when the output is not blocked. An event
// passes through the middle stage, alongside the registered read of the
// frame buffer RAM, and then through the output register.
// If m_tready stays low, one more event is held in the middle stage and
// s_tready then drops until the output moves on.
// Reset puts the receiver in its start mode with the silence length at 35
// ticks and the countdown running, so the first expiry reports ready.
module rtu_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: silence length in ticks.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	// Requests.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // rx_byte [7:0], read_index [15:8]
	input  logic [1:0]  s_tuser,   // req_type [1:0]
	// Events.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // slave_address [7:0], pdu_length [15:8],
	                               // read_data [23:16], index_valid [24], zero [31:25]
	output logic [1:0]  m_tuser    // event_res [1:0]
);

	localparam int AW = rtu_pkg::FRAME_ADDR_W;
	localparam int PW = rtu_pkg::FRAME_POS_W;

	// Receiver state.
	rtu_pkg::rx_mode_t mode_q, mode_d;
	logic [15:0]       silence_ticks_q;
	logic [15:0]       count_q, count_d;
	logic              running_q, running_d;
	logic [PW-1:0]     pos_q, pos_d;
	logic [15:0]       crc_q, crc_d;
	logic [7:0]        addr_q, addr_d;

	// Middle stage and output stage.
	logic              valid_s1, valid_s2;
	rtu_pkg::event_t   event_s1, event_s2;
	logic [7:0]        addr_s1, addr_s2;
	logic [7:0]        len_s1, len_s2;
	logic              idx_valid_s1, idx_valid_s2;
	logic [7:0]        data_s2;

	// Request decode and combinational result.
	rtu_pkg::req_t     req;
	logic [7:0]        rx_byte;
	logic [7:0]        read_index;
	logic              accept;
	logic              advance_s2;
	logic              has_res;
	rtu_pkg::event_t   res_event;
	logic [7:0]        res_addr;
	logic [7:0]        res_len;
	logic              res_idx_valid;
	logic              wr_en;
	logic [AW-1:0]     ram_waddr;
	logic              rd_en;
	logic [7:0]        ram_rdata;

	assign req        = rtu_pkg::req_t'(s_tuser);
	assign rx_byte    = s_tdata[7:0];
	assign read_index = s_tdata[15:8];

	// Handshakes: the output register frees the middle stage.
	assign advance_s2 = !valid_s2 || m_tready;
	assign s_tready   = !valid_s1 || advance_s2;
	assign accept     = s_tvalid && s_tready;
	assign cfg_ready  = 1'b1;

	// Next state and the result of the current request.
	always_comb begin
		mode_d        = mode_q;
		count_d       = count_q;
		running_d     = running_q;
		pos_d         = pos_q;
		crc_d         = crc_q;
		addr_d        = addr_q;
		has_res       = 1'b0;
		res_event     = rtu_pkg::EV_RX_READY;
		res_addr      = 8'd0;
		res_len       = 8'd0;
		res_idx_valid = 1'b0;
		wr_en         = 1'b0;
		ram_waddr     = pos_q[AW-1:0];
		rd_en         = 1'b0;
		unique case (req)
			rtu_pkg::REQ_BYTE: begin
				if (mode_q == rtu_pkg::MODE_IDLE) begin
					// A new frame starts at the head of the buffer.
					wr_en     = 1'b1;
					ram_waddr = '0;
					addr_d    = rx_byte;
					pos_d     = PW'(1);
					crc_d     = rtu_pkg::crc_byte(rtu_pkg::CRC_INIT, rx_byte);
					mode_d    = rtu_pkg::MODE_RCV;
				end else if (mode_q == rtu_pkg::MODE_RCV) begin
					if (pos_q < PW'(rtu_pkg::FRAME_MAX)) begin
						wr_en = 1'b1;
						pos_d = pos_q + PW'(1);
						crc_d = rtu_pkg::crc_byte(crc_q, rx_byte);
					end else begin
						mode_d = rtu_pkg::MODE_ERROR;
					end
				end
				count_d   = silence_ticks_q;
				running_d = 1'b1;
			end
			rtu_pkg::REQ_TICK: begin
				if (running_q) begin
					if (count_q > 16'd1) begin
						count_d = count_q - 16'd1;
					end else begin
						count_d   = 16'd0;
						running_d = 1'b0;
						mode_d    = rtu_pkg::MODE_IDLE;
						if (mode_q == rtu_pkg::MODE_INIT) begin
							has_res   = 1'b1;
							res_event = rtu_pkg::EV_RX_READY;
						end else if (mode_q == rtu_pkg::MODE_RCV) begin
							has_res = 1'b1;
							if (pos_q >= PW'(rtu_pkg::FRAME_MIN) && crc_q == 16'd0) begin
								res_event = rtu_pkg::EV_GOOD;
								res_addr  = addr_q;
								res_len   = 8'(pos_q - PW'(3));
							end else begin
								res_event = rtu_pkg::EV_BAD;
							end
						end
					end
				end
			end
			rtu_pkg::REQ_READ: begin
				has_res       = 1'b1;
				res_event     = rtu_pkg::EV_DATA;
				res_idx_valid = {1'b0, read_index} < pos_q;
				rd_en         = 1'b1;
			end
			rtu_pkg::REQ_RESTART: begin
				mode_d    = rtu_pkg::MODE_INIT;
				count_d   = silence_ticks_q;
				running_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Frame buffer.
	rtu_ram #(
		.WIDTH(8),
		.DEPTH(rtu_pkg::FRAME_MAX)
	) u_frame_ram (
		.clk    (clk),
		.wr_en  (accept && wr_en),
		.wr_addr(ram_waddr),
		.wr_data(rx_byte),
		.rd_en  (accept && rd_en),
		.rd_addr(read_index[AW-1:0]),
		.rd_data(ram_rdata)
	);

	// Receiver state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= rtu_pkg::MODE_INIT;
			silence_ticks_q <= rtu_pkg::SILENCE_RESET;
			count_q         <= rtu_pkg::SILENCE_RESET;
			running_q       <= 1'b1;
			pos_q           <= '0;
			crc_q           <= rtu_pkg::CRC_INIT;
		end else begin
			if (cfg_valid) begin
				silence_ticks_q <= cfg_data;
			end
			if (accept) begin
				mode_q    <= mode_d;
				count_q   <= count_d;
				running_q <= running_d;
				pos_q     <= pos_d;
				crc_q     <= crc_d;
			end
		end
	end

	// First frame byte, kept for the good-frame report.
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= addr_d;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= has_res;
			end else if (advance_s2) begin
				valid_s1 <= 1'b0;
			end
			if (advance_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage payloads; read data joins as the word enters the output register.
	always_ff @(posedge clk) begin
		if (accept) begin
			event_s1     <= res_event;
			addr_s1      <= res_addr;
			len_s1       <= res_len;
			idx_valid_s1 <= res_idx_valid;
		end
		if (advance_s2 && valid_s1) begin
			event_s2     <= event_s1;
			addr_s2      <= addr_s1;
			len_s2       <= len_s1;
			idx_valid_s2 <= idx_valid_s1;
			data_s2      <= idx_valid_s1 ? ram_rdata : 8'd0;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = event_s2;
	assign m_tdata  = {7'd0, idx_valid_s2, data_s2, len_s2, addr_s2};

endmodule
